// ===== rtl/canonical_huffman_encoder_top_macros.svh =====
// Assertion macros used by the checker file of the canonical Huffman encoder.
`ifndef CANONICAL_HUFFMAN_ENCODER_TOP_MACROS_SVH
`define CANONICAL_HUFFMAN_ENCODER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/chc_pkg.sv =====
// Shared types and constants of the canonical Huffman encoder.
package chc_pkg;

   localparam int DEF_NUM_SYMBOLS  = 256;
   localparam int DEF_MAX_CODE_LEN = 32;
   localparam int SYM_W            = 8;
   localparam int LEN_W            = 6;
   localparam int BYTE_W           = 8;
   localparam int CNT_W            = 6;
   localparam int QUEUE_DEPTH      = 4;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_BUILD  = 2'd1,
      FUNC_ENCODE = 2'd2,
      FUNC_FLUSH  = 2'd3
   } func_type;

   typedef struct packed {
      func_type           func;
      logic [SYM_W-1:0]   symbol;
      logic [LEN_W-1:0]   code_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               last_of_run;
   } rsp_type;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      func_type           op;
      logic [SYM_W-1:0]   symbol;
      logic [LEN_W-1:0]   length;
   } cmd_type;

   // Push side of the command queue.
   typedef struct packed {
      logic               valid;
      cmd_type            cmd;
   } push_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HIST,
      ST_PREFIX,
      ST_ASSIGN,
      ST_ENC_READ,
      ST_EMIT,
      ST_FLUSH
   } bk_state_type;

endpackage

// ===== rtl/chc_ram.sv =====
// Generic single write port RAM with one registered read port.
module chc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/chc_front.sv =====
// Front end: accepts request beats, drops out-of-range symbols and clamps lengths.
module chc_front import chc_pkg::*; #(
   parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   input  logic     queue_full,
   output push_type push
);

   logic sym_ok;
   logic keep;

   // Loads and encodes of symbols beyond the table have no effect.
   always_comb begin
      sym_ok = 32'(req_data.symbol) < NUM_SYMBOLS;
      unique case (req_data.func)
         FUNC_LOAD, FUNC_ENCODE: keep = sym_ok;
         FUNC_BUILD, FUNC_FLUSH: keep = 1'b1;
         default:                keep = 1'b1;
      endcase
   end

   assign req_ready = !queue_full;

   // Build the queued command, clamping the load length to the maximum.
   always_comb begin
      push.valid      = req_valid && !queue_full && keep;
      push.cmd.op     = req_data.func;
      push.cmd.symbol = req_data.symbol;
      if (32'(req_data.code_length) > MAX_CODE_LEN) begin
         push.cmd.length = LEN_W'(MAX_CODE_LEN);
      end else begin
         push.cmd.length = req_data.code_length;
      end
   end

endmodule

// ===== rtl/chc_fifo.sv =====
// Short command queue between the front end and the back end.
module chc_fifo import chc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   output logic     cmd_valid,
   input  logic     cmd_ready,
   output cmd_type  cmd
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PW:0]    count_ff, count_in;
   logic           do_push;
   logic           do_pop;

   assign full      = count_ff == (PW+1)'(QUEUE_DEPTH);
   assign cmd_valid = count_ff != '0;
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = cmd_valid && cmd_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ===== rtl/chc_back.sv =====
// Back end: length and code tables, canonical code build, bit packing and output register.
module chc_back import chc_pkg::*; #(
   parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SW = $clog2(NUM_SYMBOLS);
   localparam int IW = $clog2(MAX_CODE_LEN);
   localparam int BW = MAX_CODE_LEN + BYTE_W;
   localparam logic [SW:0]             SCAN_END = (SW+1)'(NUM_SYMBOLS);
   localparam logic [IW-1:0]           IDX_LAST = IW'(MAX_CODE_LEN - 1);
   localparam logic [MAX_CODE_LEN-1:0] ONES     = '1;
   localparam logic [MAX_CODE_LEN-1:0] ONE      = MAX_CODE_LEN'(1);
   localparam logic [CNT_W-1:0]        CNT_BYTE = CNT_W'(BYTE_W);

   bk_state_type            state_ff, state_in;
   logic [SW:0]             scan_ff, scan_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [SW-1:0]           rd_sym_ff, rd_sym_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [MAX_CODE_LEN-1:0] run_ff, run_in;
   logic [MAX_CODE_LEN-1:0] hist_ff [MAX_CODE_LEN];
   logic [MAX_CODE_LEN-1:0] hist_in [MAX_CODE_LEN];
   logic [BW-1:0]           buf_ff, buf_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NUM_SYMBOLS-1:0]  lt_vld_ff, lt_vld_in;
   logic                    lt_vq_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    lt_we;
   logic [SW-1:0]           lt_waddr;
   logic [LEN_W-1:0]        lt_wdata;
   logic [LEN_W-1:0]        lt_q;
   logic                    ct_we;
   logic [MAX_CODE_LEN-1:0] ct_wdata;
   logic [MAX_CODE_LEN-1:0] ct_q;
   logic [SW-1:0]           rd_addr;

   logic [LEN_W-1:0]        len_rd;
   logic [IW-1:0]           len_idx;
   logic [IW-1:0]           hist_addr;
   logic [MAX_CODE_LEN-1:0] hist_rd;
   logic [MAX_CODE_LEN-1:0] code_mask;
   logic [CNT_W-1:0]        cnt_sum;
   logic [CNT_W-1:0]        emit_rem;
   logic [CNT_W-1:0]        flush_sh;
   logic                    out_free;

   // Code length per symbol.
   chc_ram #(
      .WIDTH (LEN_W),
      .DEPTH (NUM_SYMBOLS)
   ) u_len_ram (
      .clock (clock),
      .we    (lt_we),
      .waddr (lt_waddr),
      .wdata (lt_wdata),
      .raddr (rd_addr),
      .rdata (lt_q)
   );

   // Canonical code per symbol, written by the build walk.
   chc_ram #(
      .WIDTH (MAX_CODE_LEN),
      .DEPTH (NUM_SYMBOLS)
   ) u_code_ram (
      .clock (clock),
      .we    (ct_we),
      .waddr (rd_sym_ff),
      .wdata (ct_wdata),
      .raddr (rd_addr),
      .rdata (ct_q)
   );

   // A length entry never loaded since reset reads as zero.
   assign len_rd    = lt_vq_ff ? lt_q : '0;
   assign len_idx   = IW'(len_rd - LEN_W'(1));
   assign hist_addr = (state_ff == ST_PREFIX) ? idx_ff : len_idx;
   assign hist_rd   = hist_ff[hist_addr];
   assign code_mask = ~(ONES << len_rd);
   assign cnt_sum   = cnt_ff + len_rd;
   assign emit_rem  = cnt_ff - CNT_BYTE;
   assign flush_sh  = CNT_BYTE - cnt_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Sequencer: next state, table accesses and byte emission.
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      rd_pend_in   = 1'b0;
      rd_sym_in    = rd_sym_ff;
      idx_in       = idx_ff;
      run_in       = run_ff;
      hist_in      = hist_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      lt_vld_in    = lt_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd_ready    = 1'b0;
      lt_we        = 1'b0;
      lt_waddr     = cmd.symbol[SW-1:0];
      lt_wdata     = cmd.length;
      ct_we        = 1'b0;
      ct_wdata     = '0;
      rd_addr      = scan_ff[SW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               unique case (cmd.op)
                  FUNC_LOAD: begin
                     lt_we = 1'b1;
                     lt_vld_in[cmd.symbol[SW-1:0]] = 1'b1;
                  end
                  FUNC_BUILD: begin
                     for (int i = 0; i < MAX_CODE_LEN; i++) begin
                        hist_in[i] = '0;
                     end
                     scan_in  = '0;
                     state_in = ST_HIST;
                  end
                  FUNC_ENCODE: begin
                     rd_addr  = cmd.symbol[SW-1:0];
                     state_in = ST_ENC_READ;
                  end
                  FUNC_FLUSH: begin
                     state_in = ST_FLUSH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Count the symbols of each length.
         ST_HIST: begin
            if (rd_pend_ff && len_rd != '0) begin
               hist_in[hist_addr] = hist_rd + ONE;
            end
            if (scan_ff == SCAN_END) begin
               idx_in   = '0;
               run_in   = '0;
               state_in = ST_PREFIX;
            end else begin
               rd_pend_in = 1'b1;
               rd_sym_in  = scan_ff[SW-1:0];
               scan_in    = scan_ff + 1'b1;
            end
         end

         // Turn the counts into the first code of each length.
         ST_PREFIX: begin
            hist_in[hist_addr] = run_ff;
            run_in = (run_ff + hist_rd) << 1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               scan_in  = '0;
               state_in = ST_ASSIGN;
            end
         end

         // Hand out codes in symbol order within each length.
         ST_ASSIGN: begin
            if (rd_pend_ff) begin
               ct_we = 1'b1;
               if (len_rd != '0) begin
                  ct_wdata           = hist_rd & code_mask;
                  hist_in[hist_addr] = hist_rd + ONE;
               end
            end
            if (scan_ff == SCAN_END) begin
               state_in = ST_IDLE;
            end else begin
               rd_pend_in = 1'b1;
               rd_sym_in  = scan_ff[SW-1:0];
               scan_in    = scan_ff + 1'b1;
            end
         end

         // Append the code, most significant bit first.
         ST_ENC_READ: begin
            state_in = ST_IDLE;
            if (len_rd != '0) begin
               buf_in = BW'(buf_ff << len_rd) | BW'(ct_q & code_mask);
               cnt_in = cnt_sum;
               if (cnt_sum >= CNT_BYTE) begin
                  state_in = ST_EMIT;
               end
            end
         end

         // One full byte per cycle while the output register is free, from the top of the pending bits.
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_byte    = BYTE_W'(buf_ff >> emit_rem);
               rsp_data_in.last_of_run = emit_rem < CNT_BYTE;
               cnt_in                  = emit_rem;
               if (emit_rem < CNT_BYTE) begin
                  state_in = ST_IDLE;
               end
            end
         end

         // Pad the partial byte with low zeros and empty the buffer.
         ST_FLUSH: begin
            if (cnt_ff == '0) begin
               buf_in   = '0;
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_byte    = BYTE_W'(buf_ff[BYTE_W-1:0] << flush_sh);
               rsp_data_in.last_of_run = 1'b1;
               cnt_in                  = '0;
               buf_in                  = '0;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         cnt_ff       <= '0;
         buf_ff       <= '0;
         lt_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rd_pend_ff   <= rd_pend_in;
         cnt_ff       <= cnt_in;
         buf_ff       <= buf_in;
         lt_vld_ff    <= lt_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      rd_sym_ff   <= rd_sym_in;
      idx_ff      <= idx_in;
      run_ff      <= run_in;
      hist_ff     <= hist_in;
      lt_vq_ff    <= lt_vld_ff[rd_addr];
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/canonical_huffman_encoder_top.sv =====
// Top level of the canonical Huffman encoder: front end, command queue and back end.
// Commands are registered in the queue ahead of the back end; a load writes its entry as it is taken.
// A flush moves the back end to its flush state, which registers the padded byte if bits are pending.
// An encode reads both tables, then the emit state registers each full byte while the output is free.
// A build walks the length table twice, counting lengths and then assigning codes, with the prefix step between.
// Reset clears control state, the bit buffer and the valid bit of every length entry; codes exist after a build.
module canonical_huffman_encoder_top import chc_pkg::*; #(
   parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   push_type push;
   logic     queue_full;
   logic     cmd_valid;
   logic     cmd_ready;
   cmd_type  cmd;

   chc_front #(
      .NUM_SYMBOLS  (NUM_SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push)
   );

   chc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   chc_back #(
      .NUM_SYMBOLS  (NUM_SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/chc_checker.sv =====
// Port-level checker of the canonical Huffman encoder and its bind to the top level.
`include "canonical_huffman_encoder_top_macros.svh"

module chc_checker import chc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result beat stays and holds its payload.
   `CHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp_valid dropped while stalled")
   `CHC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp_data changed while stalled")

   // Coming out of reset the block is empty and ready for input.
   `CHC_ASSERT_NOW(a_rst_quiet, $past(reset), !rsp_valid && req_ready, "not idle after reset")

   // A byte that is not the last of its run is followed directly by the next one.
   `CHC_ASSERT_NEXT(a_run_cont, rsp_valid && rsp_ready && !rsp_data.last_of_run, rsp_valid, "gap inside an encode run")

endmodule

bind canonical_huffman_encoder_top chc_checker u_chc_checker (.*);
